FILE: design/edfrts_pkg.sv
// Package for the EDF release-time scheduler.
// Holds the operation codes and the sequencer state type; no dependencies.
package edfrts_pkg;

    typedef enum logic [2:0] {
        OP_CREATE_RT    = 3'd0,
        OP_CREATE_PLAIN = 3'd1,
        OP_YIELD        = 3'd2,
        OP_FINISH       = 3'd3,
        OP_TICK         = 3'd4,
        OP_SELECT       = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_SEL_SCAN,
        ST_SEL_SHIFT,
        ST_SEL_FIFO,
        ST_MIN_SCAN,
        ST_DONE
    } state_t;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

FILE: design/edf_release_time_scheduler_unit.sv
// Top level of the EDF release-time scheduler.
// Uses edfrts_pkg; holds the task table and plain FIFO in synchronous memories.
//
// Usage: one command transaction enters on the s_axis group and exactly one
// status transaction leaves on the m_axis group. s_axis_tdata carries the
// operation, the task handle and the two time offsets; m_axis_tdata carries
// the running task, the idle wait time, the deadline counters and the error
// flag. Commands are processed one at a time by a sequencer that walks the
// deadline-sorted table entry by entry through a memory with a registered
// read; a tick or plain create does not walk the table, while a real-time
// insert or a selection visits table entries, and a yield that requeues
// then also selects. The result is held in an output register until taken;
// a new command is accepted only once the sequencer is free and that result
// has been taken, so a stalled receiver stalls the command input. Reset
// clears all counters, time and the running task; the memories need no
// clearing.
module edf_release_time_scheduler_unit #(
    parameter int MAX_RT_TASKS    = 16,
    parameter int MAX_PLAIN_TASKS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], task_handle[10:3], start_offset_ms[42:11],
    // deadline_offset_ms[74:43], zero fill [79:75]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // selected_valid[0], selected_handle[8:1], selected_is_rt[9],
    // idle_wait_until[41:10], deadlines_met[73:42], deadlines_missed[105:74],
    // error[106], zero fill [111:107]
    output logic [111:0] m_axis_tdata
);
    import edfrts_pkg::*;

    localparam int RW = $clog2(MAX_RT_TASKS);
    localparam int PW = $clog2(MAX_PLAIN_TASKS);
    localparam int RC = $clog2(MAX_RT_TASKS + 1);
    localparam int PC = $clog2(MAX_PLAIN_TASKS + 1);

    typedef struct packed {
        logic [7:0]  handle;
        logic [31:0] release_ms;
        logic [31:0] deadline_ms;
    } entry_t;

    entry_t     rt_mem [MAX_RT_TASKS];
    logic [7:0] fifo_mem [MAX_PLAIN_TASKS];

    state_t      state_reg, state_next;
    logic [RC-1:0] rt_count_reg;
    logic [PW-1:0] plain_head_reg;
    logic [PC-1:0] plain_count_reg;
    logic [31:0] now_reg;
    logic [7:0]  run_h_reg;
    logic        run_v_reg, run_rt_reg;
    logic [31:0] run_rel_reg, run_dl_reg;
    logic [31:0] met_reg, missed_reg;
    logic [RC-1:0] idx_reg;
    logic        rd_pend_reg;
    entry_t      ins_reg;
    logic        ins_yield_reg;
    logic [31:0] min_reg;
    logic [31:0] wait_reg;
    logic        err_reg;
    logic        out_v_reg;
    logic [111:0] out_reg;

    entry_t      rd_data_reg;
    logic [7:0]  fifo_rd_reg;

    logic          rd_en;
    logic [RW-1:0] rd_addr;
    logic          wr_en;
    logic [RW-1:0] wr_addr;
    entry_t        wr_data;
    logic          fwr_en;
    logic [PW-1:0] fwr_addr;
    logic [7:0]    fwr_data;
    logic [PC:0]   fifo_tail_sum;
    logic [PW-1:0] plain_head_inc;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    assign fifo_tail_sum  = (PC+1)'(plain_head_reg) + (PC+1)'(plain_count_reg);
    assign plain_head_inc = (plain_head_reg == PW'(MAX_PLAIN_TASKS - 1))
                            ? '0 : plain_head_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rt_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rt_mem[rd_addr];
        end
        if (fwr_en)
        begin
            fifo_mem[fwr_addr] <= fwr_data;
        end
        if (fwr_en && (fwr_addr == plain_head_reg))
        begin
            fifo_rd_reg <= fwr_data;
        end
        else
        begin
            fifo_rd_reg <= fifo_mem[plain_head_reg];
        end
    end

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic rt_full, plain_full;
    assign rt_full    = rt_count_reg >= RC'(MAX_RT_TASKS);
    assign plain_full = plain_count_reg >= PC'(MAX_PLAIN_TASKS);

    // Memory access is driven from the sequencer state.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[RW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[RW-1:0];
        wr_data = rd_data_reg;
        fwr_en  = 1'b0;
        fwr_addr = (fifo_tail_sum >= (PC+1)'(MAX_PLAIN_TASKS))
                   ? PW'(fifo_tail_sum - (PC+1)'(MAX_PLAIN_TASKS))
                   : PW'(fifo_tail_sum);
        fwr_data = ins_reg.handle;
        unique case (state_reg)
            ST_INS_SCAN, ST_SEL_SCAN, ST_MIN_SCAN:
            begin
                rd_en = !rd_pend_reg && (idx_reg < rt_count_reg);
            end
            ST_INS_SHIFT:
            begin
                rd_en   = !rd_pend_reg;
                rd_addr = RW'(idx_reg - RC'(1));
                wr_en   = rd_pend_reg;
            end
            ST_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_data = ins_reg;
            end
            ST_SEL_SHIFT:
            begin
                rd_en   = !rd_pend_reg;
                rd_addr = RW'(idx_reg + RC'(1));
                wr_en   = rd_pend_reg;
            end
            ST_SEL_FIFO:
            begin
                fwr_en = 1'b1;
            end
            ST_IDLE:
            begin
                fwr_en = 1'b0;
            end
            ST_DONE:
            begin
                fwr_en = 1'b0;
            end
            default:
            begin
                fwr_en = 1'b0;
            end
        endcase
    end

    // Next state.
    logic rd_hit;
    assign rd_hit = rd_pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tdata[2:0])
                        OP_CREATE_RT:
                        begin
                            state_next = rt_full ? ST_DONE : ST_INS_SCAN;
                        end
                        OP_CREATE_PLAIN:
                        begin
                            state_next = plain_full ? ST_DONE : ST_SEL_FIFO;
                        end
                        OP_YIELD:
                        begin
                            if (!run_v_reg)
                            begin
                                state_next = ST_SEL_SCAN;
                            end
                            else if (run_rt_reg)
                            begin
                                state_next = rt_full ? ST_DONE : ST_INS_SCAN;
                            end
                            else
                            begin
                                state_next = plain_full ? ST_DONE : ST_SEL_FIFO;
                            end
                        end
                        OP_FINISH:
                        begin
                            state_next = ST_SEL_SCAN;
                        end
                        OP_TICK:
                        begin
                            state_next = ST_DONE;
                        end
                        OP_SELECT:
                        begin
                            state_next = run_v_reg ? ST_DONE : ST_SEL_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                if (!rd_hit)
                begin
                    if (idx_reg >= rt_count_reg)
                    begin
                        state_next = ST_INS_PUT;
                    end
                end
                else if (rd_data_reg.deadline_ms > ins_reg.deadline_ms)
                begin
                    state_next = ST_INS_SHIFT;
                end
            end
            ST_INS_SHIFT:
            begin
                if (idx_reg == min_reg[RC-1:0])
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT, ST_SEL_FIFO:
            begin
                state_next = ins_yield_reg ? ST_SEL_SCAN : ST_DONE;
            end
            ST_SEL_SCAN:
            begin
                if (!rd_hit)
                begin
                    if (idx_reg < rt_count_reg)
                    begin
                        state_next = ST_SEL_SCAN;
                    end
                    else if (plain_count_reg != '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = (rt_count_reg == '0) ? ST_DONE : ST_MIN_SCAN;
                    end
                end
                else if (rd_data_reg.release_ms <= now_reg)
                begin
                    state_next = ST_SEL_SHIFT;
                end
            end
            ST_SEL_SHIFT:
            begin
                if (idx_reg + RC'(1) >= rt_count_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MIN_SCAN:
            begin
                if (!rd_hit && (idx_reg >= rt_count_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The sequencer: all working states update registers here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rt_count_reg    <= '0;
            plain_head_reg  <= '0;
            plain_count_reg <= '0;
            now_reg         <= '0;
            run_h_reg       <= '0;
            run_v_reg       <= 1'b0;
            run_rt_reg      <= 1'b0;
            run_rel_reg     <= '0;
            run_dl_reg      <= '0;
            met_reg         <= '0;
            missed_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            out_v_reg       <= 1'b0;
            idx_reg         <= '0;
            ins_yield_reg   <= 1'b0;
            wait_reg        <= '0;
            err_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_v_reg && m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wait_reg <= '0;
                        err_reg  <= ((s_axis_tdata[2:0] == OP_CREATE_RT) && rt_full)
                                    || ((s_axis_tdata[2:0] == OP_CREATE_PLAIN)
                                        && plain_full);
                        idx_reg  <= '0;
                        rd_pend_reg <= 1'b0;
                        ins_yield_reg <= (s_axis_tdata[2:0] == OP_YIELD);
                        unique case (s_axis_tdata[2:0])
                            OP_CREATE_RT:
                            begin
                                ins_reg.handle      <= s_axis_tdata[10:3];
                                ins_reg.release_ms  <= now_reg + s_axis_tdata[42:11];
                                ins_reg.deadline_ms <= now_reg + s_axis_tdata[42:11]
                                                       + s_axis_tdata[74:43];
                            end
                            OP_CREATE_PLAIN:
                            begin
                                ins_reg.handle <= s_axis_tdata[10:3];
                            end
                            OP_YIELD:
                            begin
                                ins_reg.handle      <= run_h_reg;
                                ins_reg.release_ms  <= run_rel_reg;
                                ins_reg.deadline_ms <= run_dl_reg;
                            end
                            OP_FINISH:
                            begin
                                if (run_v_reg && run_rt_reg)
                                begin
                                    if (now_reg <= run_dl_reg)
                                    begin
                                        if (met_reg != COUNT_MAX)
                                        begin
                                            met_reg <= met_reg + 32'd1;
                                        end
                                    end
                                    else if (missed_reg != COUNT_MAX)
                                    begin
                                        missed_reg <= missed_reg + 32'd1;
                                    end
                                end
                                run_v_reg <= 1'b0;
                            end
                            OP_TICK:
                            begin
                                now_reg <= now_reg + 32'd1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                // Find the first entry with a later deadline.
                ST_INS_SCAN:
                begin
                    if (!rd_hit)
                    begin
                        if (idx_reg < rt_count_reg)
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (rd_data_reg.deadline_ms <= ins_reg.deadline_ms)
                        begin
                            idx_reg <= idx_reg + RC'(1);
                        end
                        else
                        begin
                            min_reg[RC-1:0] <= idx_reg;
                            idx_reg   <= rt_count_reg;
                        end
                    end
                end
                // Move entries up one place, from the top down to the slot.
                ST_INS_SHIFT:
                begin
                    if (idx_reg == min_reg[RC-1:0])
                    begin
                    end
                    else if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= idx_reg - RC'(1);
                    end
                end
                ST_INS_PUT:
                begin
                    rt_count_reg <= rt_count_reg + RC'(1);
                    idx_reg      <= '0;
                    if (ins_yield_reg)
                    begin
                        run_v_reg <= 1'b0;
                    end
                end
                // Plain push, or a yield of a plain task followed by selection.
                ST_SEL_FIFO:
                begin
                    plain_count_reg <= plain_count_reg + PC'(1);
                    if (ins_yield_reg)
                    begin
                        run_v_reg <= 1'b0;
                        idx_reg   <= '0;
                    end
                end
                // Earliest-deadline released entry, else the plain FIFO head, else idle.
                ST_SEL_SCAN:
                begin
                    if (!rd_hit)
                    begin
                        if (idx_reg < rt_count_reg)
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                        else if (plain_count_reg != '0)
                        begin
                            run_h_reg      <= fifo_rd_reg;
                            run_v_reg      <= 1'b1;
                            run_rt_reg     <= 1'b0;
                            run_rel_reg    <= '0;
                            run_dl_reg     <= '0;
                            plain_head_reg <= plain_head_inc;
                            plain_count_reg <= plain_count_reg - PC'(1);
                        end
                        else
                        begin
                            run_v_reg   <= 1'b0;
                            run_rt_reg  <= 1'b0;
                            run_h_reg   <= '0;
                            run_rel_reg <= '0;
                            run_dl_reg  <= '0;
                            min_reg     <= COUNT_MAX;
                            idx_reg     <= '0;
                        end
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (rd_data_reg.release_ms <= now_reg)
                        begin
                            run_h_reg   <= rd_data_reg.handle;
                            run_rel_reg <= rd_data_reg.release_ms;
                            run_dl_reg  <= rd_data_reg.deadline_ms;
                            run_rt_reg  <= 1'b1;
                            run_v_reg   <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + RC'(1);
                        end
                    end
                end
                // Close the gap left by the selected entry.
                ST_SEL_SHIFT:
                begin
                    if (idx_reg + RC'(1) >= rt_count_reg)
                    begin
                        rt_count_reg <= rt_count_reg - RC'(1);
                    end
                    else if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= idx_reg + RC'(1);
                    end
                end
                // Smallest pending release time.
                ST_MIN_SCAN:
                begin
                    if (!rd_hit)
                    begin
                        if (idx_reg < rt_count_reg)
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            wait_reg <= min_reg;
                        end
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= idx_reg + RC'(1);
                        if (rd_data_reg.release_ms < min_reg)
                        begin
                            min_reg <= rd_data_reg.release_ms;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_v_reg || m_axis_tready)
                    begin
                        out_v_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_v_reg || m_axis_tready))
        begin
            out_reg <= {5'd0, err_reg, missed_reg, met_reg, wait_reg,
                        run_v_reg & run_rt_reg,
                        run_v_reg ? run_h_reg : 8'd0, run_v_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rt_count_reg <= RC'(MAX_RT_TASKS))
        else $error("task table count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        plain_count_reg <= PC'(MAX_PLAIN_TASKS))
        else $error("plain count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("command accepted but sequencer stayed idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("ready raised while busy");
endmodule
